// ===== rtl/hdlcf_pkg.sv =====
// hdlcf_pkg: types and constants shared by the framer modules.
// No dependencies.
package hdlcf_pkg;

   localparam logic [7:0] STUFF_MASK  = 8'h20;
   localparam int         CSR_INDEX_W = 3;
   localparam int         DESC_BYTES  = 4;
   localparam int         DESC_IDX_W  = 2;

   typedef enum logic [1:0] {
      OP_OPEN  = 2'd0,
      OP_BODY  = 2'd1,
      OP_CLOSE = 2'd2,
      OP_ACK   = 2'd3
   } op_type;

   localparam logic [CSR_INDEX_W-1:0] REG_FLAG    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ESCAPE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ADDRESS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CTL0    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CTL1    = 3'd4;

   typedef struct packed {
      logic [7:0] flag_value;
      logic [7:0] escape_value;
      logic [7:0] address_value;
      logic [7:0] control_seq_zero;
      logic [7:0] control_seq_one;
   } cfg_type;

   // one queued job: bytes[0] goes first; raw bytes bypass stuffing
   typedef struct packed {
      logic [DESC_BYTES-1:0][7:0] bytes;
      logic [DESC_BYTES-1:0]      raw;
      logic [DESC_IDX_W-1:0]      last_idx;
   } desc_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } push_type;

   typedef struct packed {
      logic     valid;
      logic     full;
      desc_type desc;
   } qstat_type;

endpackage

// ===== rtl/hdlcf_if.sv =====
// hdlcf_req_if / hdlcf_rsp_if: valid/ready channels of the framer.
// Depends on nothing.
interface hdlcf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] body_byte;
   modport source (output valid, output operation, output body_byte, input ready);
   modport sink   (input valid, input operation, input body_byte, output ready);
endinterface

interface hdlcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       run_last;
   modport source (output valid, output line_byte, output run_last, input ready);
   modport sink   (input valid, input line_byte, input run_last, output ready);
endinterface

// ===== rtl/hdlcf_front.sv =====
// hdlcf_front: accepts items, tracks frame state, builds line jobs.
// Depends on hdlcf_pkg and hdlcf_req_if.
module hdlcf_front (
   input  logic                  clock,
   input  logic                  reset,
   hdlcf_req_if.sink             req,
   input  hdlcf_pkg::cfg_type    cfg,
   input  logic                  q_full,
   output hdlcf_pkg::push_type   push
);

   logic       seq_ff, seq_in;
   logic [7:0] check_ff, check_in;
   logic       in_frame_ff, in_frame_in;
   logic       accept;
   logic [7:0] ctl;
   hdlcf_pkg::op_type op;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign op        = hdlcf_pkg::op_type'(req.operation);
   assign ctl       = seq_ff ? cfg.control_seq_one : cfg.control_seq_zero;

   always_comb begin
      seq_in      = seq_ff;
      check_in    = check_ff;
      in_frame_in = in_frame_ff;
      push        = '0;
      unique case (op)
         hdlcf_pkg::OP_OPEN: begin
            push.desc.bytes    = {cfg.address_value ^ ctl, ctl, cfg.address_value,
                                  cfg.flag_value};
            push.desc.raw      = 4'b0001;
            push.desc.last_idx = 2'd3;
            push.valid         = accept;
            if (accept) begin
               check_in    = '0;
               in_frame_in = 1'b1;
            end
         end
         hdlcf_pkg::OP_BODY: begin
            push.desc.bytes[0] = req.body_byte;
            push.desc.last_idx = 2'd0;
            push.valid         = accept && in_frame_ff;
            if (accept && in_frame_ff) begin
               check_in = check_ff ^ req.body_byte;
            end
         end
         hdlcf_pkg::OP_CLOSE: begin
            push.desc.bytes[0] = check_ff;
            push.desc.bytes[1] = cfg.flag_value;
            push.desc.raw      = 4'b0010;
            push.desc.last_idx = 2'd1;
            push.valid         = accept && in_frame_ff;
            if (accept && in_frame_ff) begin
               check_in    = '0;
               in_frame_in = 1'b0;
            end
         end
         default: begin
            if (accept) begin
               seq_in = !seq_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= 1'b0;
         check_ff    <= '0;
         in_frame_ff <= 1'b0;
      end else begin
         seq_ff      <= seq_in;
         check_ff    <= check_in;
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

// ===== rtl/hdlcf_queue.sv =====
// hdlcf_queue: short job queue between front and back.
// Depends on hdlcf_pkg.
module hdlcf_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hdlcf_pkg::push_type    push,
   input  logic                   pop,
   output hdlcf_pkg::qstat_type   stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   hdlcf_pkg::desc_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign stat.valid = count_ff != '0;
   assign stat.full  = count_ff == CNT_FULL;
   assign stat.desc  = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !stat.full;
   assign do_pop     = pop && stat.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/hdlcf_back.sv =====
// hdlcf_back: walks queued jobs, applies byte stuffing, drives the line.
// Depends on hdlcf_pkg and hdlcf_rsp_if.
module hdlcf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  hdlcf_pkg::cfg_type    cfg,
   input  hdlcf_pkg::qstat_type  q,
   output logic                  pop,
   hdlcf_rsp_if.source           rsp
);

   hdlcf_pkg::desc_type cur_ff, cur_in;
   logic                              cur_valid_ff, cur_valid_in;
   logic [hdlcf_pkg::DESC_IDX_W-1:0]  idx_ff, idx_in;
   logic                              esc_ff, esc_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [7:0]                        rsp_byte_ff, rsp_byte_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic [7:0]                        cur_byte;
   logic                              need_stuff, step, at_last, finish;

   assign cur_byte   = cur_ff.bytes[idx_ff];
   assign need_stuff = !cur_ff.raw[idx_ff] &&
                       ((cur_byte == cfg.flag_value) || (cur_byte == cfg.escape_value));
   assign step       = cur_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign at_last    = idx_ff == cur_ff.last_idx;
   assign finish     = step && (esc_ff || !need_stuff) && at_last;
   assign pop        = q.valid && (!cur_valid_ff || finish);

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.line_byte = rsp_byte_ff;
   assign rsp.run_last  = rsp_last_ff;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      esc_in       = esc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         if (esc_ff) begin
            rsp_byte_in = cur_byte ^ hdlcf_pkg::STUFF_MASK;
            rsp_last_in = at_last;
            esc_in      = 1'b0;
            idx_in      = idx_ff + 1'b1;
         end else if (need_stuff) begin
            rsp_byte_in = cfg.escape_value;
            rsp_last_in = 1'b0;
            esc_in      = 1'b1;
         end else begin
            rsp_byte_in = cur_byte;
            rsp_last_in = at_last;
            idx_in      = idx_ff + 1'b1;
         end
      end
      if (pop) begin
         cur_in       = q.desc;
         cur_valid_in = 1'b1;
         idx_in       = '0;
         esc_in       = 1'b0;
      end else if (finish) begin
         cur_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         esc_ff       <= esc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/hdlc_style_tx_framer_unit.sv =====
// hdlc_style_tx_framer_unit: top level of the flag-delimited transmit framer.
// Depends on hdlcf_pkg, hdlcf_if, hdlcf_front, hdlcf_queue, hdlcf_back.
//
//   channel  dir  handshake     payload
//   req_if   in   valid/ready   operation[1:0], body_byte[7:0]
//   rsp_if   out  valid/ready   line_byte[7:0], run_last
//   csr      in   csr_we        csr_index[2:0], csr_wdata[7:0]
//
// One line byte per cycle unless stalled: body 1-2 bytes, open 4-7, close 2-3.
// The back walker (one stuffed byte a cycle) sets the rate; the queue
// lets the front take items while the output register is stalled.
// Reset is synchronous; state and CSR registers reset, data registers do not.
// An item's bytes pass the queue, job and output registers; an ack makes none.
module hdlc_style_tx_framer_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   hdlcf_req_if.sink                            req_if,
   hdlcf_rsp_if.source                          rsp_if,
   input  logic                                 csr_we,
   input  logic [hdlcf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                           csr_wdata
);

   hdlcf_pkg::cfg_type   cfg_ff, cfg_in;
   hdlcf_pkg::push_type  push;
   hdlcf_pkg::qstat_type qstat;
   logic                 pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            hdlcf_pkg::REG_FLAG:    cfg_in.flag_value       = csr_wdata;
            hdlcf_pkg::REG_ESCAPE:  cfg_in.escape_value     = csr_wdata;
            hdlcf_pkg::REG_ADDRESS: cfg_in.address_value    = csr_wdata;
            hdlcf_pkg::REG_CTL0:    cfg_in.control_seq_zero = csr_wdata;
            hdlcf_pkg::REG_CTL1:    cfg_in.control_seq_one  = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_value       <= 8'h7E;
         cfg_ff.escape_value     <= 8'h7D;
         cfg_ff.address_value    <= 8'h03;
         cfg_ff.control_seq_zero <= 8'h00;
         cfg_ff.control_seq_one  <= 8'h40;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hdlcf_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_if),
      .cfg    (cfg_ff),
      .q_full (qstat.full),
      .push   (push)
   );

   hdlcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .stat  (qstat)
   );

   hdlcf_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .q     (qstat),
      .pop   (pop),
      .rsp   (rsp_if)
   );

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !qstat.full)
      else $error("job pushed into full queue");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> qstat.valid)
      else $error("pop from empty queue");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("line byte valid right after reset");
`endif

endmodule
